@@ hdl/dilated_causal_conv1d_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dilated causal convolution block
// Shared helpers for concurrent property checks.
// ----------------------------------------------------------------------------
`ifndef DILATED_CAUSAL_CONV1D_MACROS_SVH
`define DILATED_CAUSAL_CONV1D_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/dcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcc_pkg
// Types and codes shared by the convolution controller, datapath and checker.
// ----------------------------------------------------------------------------
`default_nettype none
package dcc_pkg;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_START  = 2'd3
  } req_kind_t;

  localparam logic [1:0] CFG_IN_CHANNELS  = 2'd0;
  localparam logic [1:0] CFG_OUT_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_KERNEL_TAPS  = 2'd2;
  localparam logic [1:0] CFG_DILATION     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // controller -> datapath
  typedef struct packed {
    logic wr_weight;  // store incoming weight
    logic wr_bias;    // store incoming bias
    logic wr_hist;    // store incoming sample
    logic mac;        // issue one multiply-accumulate
    logic tap_ok;     // tap lies inside valid history
    logic first;      // first product of an output channel
    logic emit;       // round accumulator into output register
    logic last_co;    // emitted result is last of the step
  } dcc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_fire;   // result transaction completed
  } dcc_status_t;

endpackage
`default_nettype wire

@@ hdl/dcc_if.sv @@
// ----------------------------------------------------------------------------
// dcc_in_if / dcc_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [10:0] address;
  logic signed [15:0] value;

  modport source (output valid, req_type, address, value, input ready);
  modport sink   (input valid, req_type, address, value, output ready);
endinterface

interface dcc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_value;
  logic [3:0]  out_channel;
  logic        last;

  modport source (output valid, out_value, out_channel, last, input ready);
  modport sink   (input valid, out_value, out_channel, last, output ready);
endinterface
`default_nettype wire

@@ hdl/dcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcc_ctrl
// Sequencer: config registers, step bookkeeping and MAC loop counters.
// ----------------------------------------------------------------------------
`default_nettype none
module dcc_ctrl #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_TAPS         = 8,
  parameter int MAX_DILATION     = 16,
  parameter int HISTORY_STEPS    = 128,
  localparam int WD   = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS,
  localparam int WAW  = (WD > 1) ? $clog2(WD) : 1,
  localparam int HD   = HISTORY_STEPS * MAX_IN_CHANNELS,
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1,
  localparam int COW  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [dcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_req_type,
  input  wire dcc_pkg::dcc_status_t       status,
  output dcc_pkg::dcc_cmd_t               cmd,
  output logic [HAW-1:0]                  hist_waddr,
  output logic [HAW-1:0]                  hist_raddr,
  output logic [WAW-1:0]                  w_raddr,
  output logic [COW-1:0]                  co
);
  import dcc_pkg::*;

  localparam int HW  = (HISTORY_STEPS > 1) ? $clog2(HISTORY_STEPS) : 1;
  localparam int CNW = $clog2(MAX_IN_CHANNELS + 1);
  localparam int CIW = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int KIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SSW = $clog2(HISTORY_STEPS + 1);
  localparam int LW  = $clog2(MAX_TAPS * MAX_DILATION + 1);
  localparam int CMW = (LW > SSW) ? LW : SSW;
  localparam int SLW = HW + 7;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT, S_WAIT} state_t;

  state_t           state_r;
  logic [4:0]       in_ch_r, out_ch_r, dil_r;
  logic [3:0]       taps_r;
  logic [HW-1:0]    head_r;
  logic [CNW-1:0]   count_r;
  logic [SSW-1:0]   steps_r;
  logic [CIW-1:0]   ci_r;
  logic [KIW-1:0]   ki_r;
  logic [COW-1:0]   co_r;
  logic [WAW-1:0]   widx_r;
  logic [LW-1:0]    lag_r;
  logic [HW-1:0]    slot_r;
  logic             drain_r;

  logic [4:0] cin, cout, dil;
  logic [3:0] taps;
  logic       fire, is_sample, step_done, ci_end, ki_end, co_end;
  logic [SLW-1:0] slot_nxt;

  function automatic logic [4:0] clamp5(input logic [4:0] v, input int hi);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (32'(v) > hi) r = 5'(hi);
    else r = v;
    return r;
  endfunction

  always_comb begin
    cin  = clamp5(in_ch_r, MAX_IN_CHANNELS);
    cout = clamp5(out_ch_r, MAX_OUT_CHANNELS);
    dil  = clamp5(dil_r, MAX_DILATION);
    taps = 4'(clamp5({1'b0, taps_r}, MAX_TAPS));
  end

  assign in_ready  = (state_r == S_IDLE);
  assign fire      = in_valid && in_ready;
  assign is_sample = (in_req_type == REQ_SAMPLE);
  assign step_done = (8'(count_r) + 8'd1) >= 8'(cin);
  assign ci_end    = 8'(ci_r) == 8'(cin) - 8'd1;
  assign ki_end    = 8'(ki_r) == 8'(taps) - 8'd1;
  assign co_end    = 8'(co_r) == 8'(cout) - 8'd1;

  // previous tap's slot, wrapping around the ring of history steps
  always_comb begin
    if (SLW'(slot_r) >= SLW'(dil)) slot_nxt = SLW'(slot_r) - SLW'(dil);
    else slot_nxt = SLW'(slot_r) + SLW'(HISTORY_STEPS) - SLW'(dil);
  end

  always_comb begin
    cmd           = '0;
    cmd.wr_weight = fire && (in_req_type == REQ_WEIGHT);
    cmd.wr_bias   = fire && (in_req_type == REQ_BIAS);
    cmd.wr_hist   = fire && is_sample && (32'(count_r) < MAX_IN_CHANNELS);
    cmd.mac       = (state_r == S_RUN);
    cmd.tap_ok    = (CMW'(lag_r) <= CMW'(steps_r)) && (32'(lag_r) < HISTORY_STEPS);
    cmd.first     = (ki_r == '0) && (ci_r == '0);
    cmd.emit      = (state_r == S_EMIT);
    cmd.last_co   = co_end;
  end

  assign hist_waddr = HAW'(head_r) * HAW'(MAX_IN_CHANNELS) + HAW'(count_r);
  assign hist_raddr = HAW'(slot_r) * HAW'(MAX_IN_CHANNELS) + HAW'(ci_r);
  assign w_raddr    = widx_r;
  assign co         = co_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_ch_r  <= 5'd1;
      out_ch_r <= 5'd1;
      taps_r   <= 4'd1;
      dil_r    <= 5'd1;
      head_r   <= '0;
      count_r  <= '0;
      steps_r  <= '0;
      ci_r     <= '0;
      ki_r     <= '0;
      co_r     <= '0;
      widx_r   <= '0;
      lag_r    <= '0;
      slot_r   <= '0;
      drain_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IN_CHANNELS:  in_ch_r  <= cfg_wdata;
          CFG_OUT_CHANNELS: out_ch_r <= cfg_wdata;
          CFG_KERNEL_TAPS:  taps_r   <= cfg_wdata[3:0];
          CFG_DILATION:     dil_r    <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (fire && (in_req_type == REQ_START)) begin
            count_r <= '0;
            steps_r <= '0;
          end else if (fire && is_sample) begin
            if (step_done) begin
              count_r <= '0;
              state_r <= S_RUN;
              ci_r    <= '0;
              ki_r    <= '0;
              co_r    <= '0;
              widx_r  <= '0;
              lag_r   <= '0;
              slot_r  <= head_r;
            end else begin
              count_r <= count_r + CNW'(1);
            end
          end
        end
        S_RUN: begin
          widx_r <= widx_r + WAW'(1);
          if (ci_end) begin
            ci_r <= '0;
            if (ki_end) begin
              state_r <= S_DRAIN;
              drain_r <= 1'b0;
            end else begin
              ki_r   <= ki_r + KIW'(1);
              lag_r  <= lag_r + LW'(dil);
              slot_r <= HW'(slot_nxt);
            end
          end else begin
            ci_r <= ci_r + CIW'(1);
          end
        end
        S_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) state_r <= S_EMIT;
        end
        S_EMIT: state_r <= S_WAIT;
        S_WAIT: begin
          if (status.out_fire) begin
            if (co_end) begin
              state_r <= S_IDLE;
              head_r  <= (32'(head_r) == HISTORY_STEPS - 1) ? '0 : head_r + HW'(1);
              if (32'(steps_r) < HISTORY_STEPS) steps_r <= steps_r + SSW'(1);
            end else begin
              state_r <= S_RUN;
              co_r    <= co_r + COW'(1);
              ci_r    <= '0;
              ki_r    <= '0;
              lag_r   <= '0;
              slot_r  <= head_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dcc_datapath.sv @@
// ----------------------------------------------------------------------------
// dcc_datapath
// Weight/bias/history stores, pipelined MAC and rounding output register.
// ----------------------------------------------------------------------------
`default_nettype none
module dcc_datapath #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_TAPS         = 8,
  parameter int HISTORY_STEPS    = 128,
  localparam int WD   = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS,
  localparam int WAW  = (WD > 1) ? $clog2(WD) : 1,
  localparam int HD   = HISTORY_STEPS * MAX_IN_CHANNELS,
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1,
  localparam int COW  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dcc_pkg::dcc_cmd_t  cmd,
  output dcc_pkg::dcc_status_t    status,
  input  wire logic [10:0]        in_address,
  input  wire logic signed [15:0] in_value,
  input  wire logic [HAW-1:0]     hist_waddr,
  input  wire logic [HAW-1:0]     hist_raddr,
  input  wire logic [WAW-1:0]     w_raddr,
  input  wire logic [COW-1:0]     co,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_value,
  output logic [3:0]              out_channel,
  output logic                    out_last
);
  import dcc_pkg::*;

  localparam int ACW = 34 + $clog2(MAX_IN_CHANNELS * MAX_TAPS + 1);

  logic signed [15:0] weight_mem [WD];
  logic signed [15:0] hist_mem   [HD];
  logic signed [15:0] bias_r     [MAX_OUT_CHANNELS];

  logic signed [15:0] w_q_r, x_q_r;
  logic               mac1_r, ok1_r, first1_r, mac2_r, first2_r;
  logic signed [31:0] prod_r;
  logic signed [ACW-1:0] acc_r, acc_base, q, r;
  logic signed [15:0] sat;
  logic               out_valid_r, last_r;
  logic signed [15:0] out_value_r;
  logic [3:0]         out_channel_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && (32'(in_address) < WD)) weight_mem[WAW'(in_address)] <= in_value;
    if (cmd.wr_hist) hist_mem[hist_waddr] <= in_value;
    w_q_r <= weight_mem[w_raddr];
    x_q_r <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias && (32'(in_address) < MAX_OUT_CHANNELS)) bias_r[COW'(in_address)] <= in_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac1_r <= 1'b0;
      mac2_r <= 1'b0;
    end else begin
      mac1_r <= cmd.mac;
      mac2_r <= mac1_r;
    end
  end

  // bias enters aligned to the product's binary point
  assign acc_base = first2_r ? (ACW'(bias_r[co]) <<< 12) : acc_r;

  always_ff @(posedge clk) begin
    ok1_r    <= cmd.tap_ok;
    first1_r <= cmd.first;
    first2_r <= first1_r;
    prod_r   <= ok1_r ? (32'(w_q_r) * 32'(x_q_r)) : '0;
    if (mac2_r) acc_r <= acc_base + ACW'(prod_r);
  end

  // round half up, then saturate
  always_comb begin
    q = acc_r + ACW'(2048);
    r = q >>> 12;
    if (r > ACW'(32767)) sat = 16'sh7fff;
    else if (r < -ACW'(32768)) sat = -16'sh8000;
    else sat = 16'(r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r   <= sat;
      out_channel_r <= 4'(co);
      last_r        <= cmd.last_co;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_channel     = out_channel_r;
  assign out_last        = last_r;
  assign status.out_fire = out_valid_r && out_ready;

endmodule
`default_nettype wire

@@ hdl/dilated_causal_conv1d.sv @@
// ----------------------------------------------------------------------------
// dilated_causal_conv1d
// Streaming multi-channel dilated causal 1-D convolution with bias (Q3.12).
// ----------------------------------------------------------------------------
//  channel  | direction | payload                          | handshake
//  in_s     | sink      | req_type, address, value         | valid/ready
//  out_s    | source    | out_value, out_channel, last     | valid/ready
//  cfg_*    | sink      | cfg_index, cfg_wdata             | cfg_we only
//
//  Writes, sequence starts and non-final samples leave the block idle and ready.
//  The final sample of a step runs, per output channel, one MAC for each
//  input channel and tap on the single shared multiplier, then pipeline
//  drain and emit, then one result transaction; input is held off meanwhile.
//  Result stalls hold the sequencer; the next channel starts after the take.
//  Reset (synchronous, active low) clears control only; stores start unknown.
// ----------------------------------------------------------------------------
`default_nettype none
module dilated_causal_conv1d #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_TAPS         = 8,
  parameter int MAX_DILATION     = 16,
  parameter int HISTORY_STEPS    = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  dcc_in_if.sink                                in_s,
  dcc_out_if.source                             out_s
);
  import dcc_pkg::*;

  localparam int WD  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int HD  = HISTORY_STEPS * MAX_IN_CHANNELS;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int COW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

  dcc_cmd_t        cmd;
  dcc_status_t     status;
  logic [HAW-1:0]  hist_waddr, hist_raddr;
  logic [WAW-1:0]  w_raddr;
  logic [COW-1:0]  co;

  // sequencer: step bookkeeping, loop counters, tap validity
  dcc_ctrl #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_TAPS        (MAX_TAPS),
    .MAX_DILATION    (MAX_DILATION),
    .HISTORY_STEPS   (HISTORY_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_s.valid),
    .in_ready   (in_s.ready),
    .in_req_type(in_s.req_type),
    .status     (status),
    .cmd        (cmd),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr),
    .w_raddr    (w_raddr),
    .co         (co)
  );

  // stores, MAC pipeline (read, multiply, accumulate) and output register
  dcc_datapath #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_TAPS        (MAX_TAPS),
    .HISTORY_STEPS   (HISTORY_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_address (in_s.address),
    .in_value   (in_s.value),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr),
    .w_raddr    (w_raddr),
    .co         (co),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .out_value  (out_s.out_value),
    .out_channel(out_s.out_channel),
    .out_last   (out_s.last)
  );

endmodule
`default_nettype wire

@@ hdl/dcc_checker.sv @@
// ----------------------------------------------------------------------------
// dcc_checker
// Port-level temporal checks, bound onto the convolution top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dilated_causal_conv1d_macros.svh"
module dcc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_req_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_last
);
  import dcc_pkg::*;

  `DCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `DCC_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `DCC_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_last, !out_valid)
  `DCC_ASSERT_NEXT(a_write_quick, clk, rst_n, in_valid && in_ready && (in_req_type != REQ_SAMPLE), in_ready)

endmodule

bind dilated_causal_conv1d dcc_checker u_dcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .in_req_type(in_s.req_type),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_last   (out_s.last)
);
`default_nettype wire
